// ===== hdl/rffa_pkg.sv =====
// Shared types, codes and constants of the radio frame filter with auto-ACK.
package rffa_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0]  MAX_PAYLOAD = 8'd240;
   localparam logic [15:0] BROADCAST_ID = 16'hFFFF;
   localparam logic [8:0]  HDR_BYTES = 9'd8;
   localparam logic [8:0]  RX_INDEX_MAX = 9'd511;
   localparam logic [7:0]  ACK_PAYLOAD_LEN = 8'd2;

   localparam logic [1:0] CMD_RX_BYTE  = 2'd0;
   localparam logic [1:0] CMD_TX_START = 2'd1;
   localparam logic [1:0] CMD_TX_BYTE  = 2'd2;

   localparam logic [1:0] KIND_RX_BYTE = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_TX_BYTE = 2'd2;

   localparam logic [1:0] STATUS_DELIVERED = 2'd0;
   localparam logic [1:0] STATUS_SHORT     = 2'd1;
   localparam logic [1:0] STATUS_NOT_HERE  = 2'd2;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

   localparam logic [1:0] CSR_NODE_ID  = 2'd0;
   localparam logic [1:0] CSR_ACK_TYPE = 2'd1;
   localparam logic [1:0] CSR_ENABLED  = 2'd2;

   localparam logic [15:0] RESET_NODE_ID  = 16'd0;
   localparam logic [7:0]  RESET_ACK_TYPE = 8'd4;
   localparam logic        RESET_ENABLED  = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  data_byte;
      logic        rx_last;
      logic [7:0]  tx_type;
      logic [15:0] tx_dest;
      logic [7:0]  tx_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic        frame_end;
      logic [7:0]  msg_type;
      logic [15:0] source_id;
      logic [15:0] dest_id;
      logic [15:0] packet_id;
      logic [7:0]  length;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_RX     = 2'd0,
      JOB_TXHDR  = 2'd1,
      JOB_TXBYTE = 2'd2
   } job_op_type;

   typedef struct packed {
      job_op_type  op;
      logic        rx_put;
      logic        sum;
      logic        ack;
      logic        fend;
      logic [7:0]  data_byte;
      logic [1:0]  status;
      logic [7:0]  sum_type;
      logic [15:0] sum_src;
      logic [15:0] sum_dest;
      logic [15:0] sum_pkt;
      logic [7:0]  sum_len;
      logic [7:0]  tx_type;
      logic [15:0] tx_dest;
      logic [7:0]  tx_len;
      logic [15:0] pid;
   } job_type;

endpackage

// ===== hdl/rffa_front.sv =====
// Front end: accepts input beats, runs the receive and transmit state and issues jobs.
module rffa_front (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      node_id,
   input  logic [7:0]       ack_type,
   input  logic             enabled,
   input  logic             req_valid,
   output logic             req_ready,
   input  rffa_pkg::req_type req_data,
   input  logic             q_full,
   output logic             push_valid,
   output rffa_pkg::job_type push_job
);

   typedef enum logic [2:0] {
      MODE_HEADER  = 3'b001,
      MODE_PAYLOAD = 3'b010,
      MODE_DISCARD = 3'b100
   } rx_mode_type;

   rx_mode_type rx_mode_ff, rx_mode_in;
   logic [8:0]  rx_index_ff, rx_index_in;
   logic [7:0]  hdr_type_ff, hdr_type_in;
   logic [15:0] hdr_source_ff, hdr_source_in;
   logic [15:0] hdr_dest_ff, hdr_dest_in;
   logic [15:0] hdr_packet_ff, hdr_packet_in;
   logic [7:0]  hdr_length_ff, hdr_length_in;
   logic [15:0] id_counter_ff, id_counter_in;
   logic [7:0]  tx_remaining_ff, tx_remaining_in;

   logic             accept;
   logic             for_us;
   logic [8:0]       pay_offset;
   logic [7:0]       tx_len;
   logic [1:0]       status;
   rffa_pkg::job_type job;
   logic             job_valid;

   assign req_ready = !q_full;
   assign accept = req_valid && req_ready;

   always_comb begin
      rx_mode_in = rx_mode_ff;
      rx_index_in = rx_index_ff;
      hdr_type_in = hdr_type_ff;
      hdr_source_in = hdr_source_ff;
      hdr_dest_in = hdr_dest_ff;
      hdr_packet_in = hdr_packet_ff;
      hdr_length_in = hdr_length_ff;
      id_counter_in = id_counter_ff;
      tx_remaining_in = tx_remaining_ff;
      job = '0;
      job_valid = 1'b0;
      for_us = 1'b0;
      pay_offset = rx_index_ff - rffa_pkg::HDR_BYTES;
      tx_len = req_data.tx_length;
      status = rffa_pkg::STATUS_DELIVERED;

      if (accept && enabled) begin
         case (req_data.cmd)
            rffa_pkg::CMD_RX_BYTE: begin
               job.op = rffa_pkg::JOB_RX;
               if (rx_mode_ff == MODE_HEADER) begin
                  if (rx_index_ff == 9'd0) begin
                     hdr_type_in = '0;
                     hdr_source_in = '0;
                     hdr_dest_in = '0;
                     hdr_packet_in = '0;
                     hdr_length_in = '0;
                  end
                  case (rx_index_ff[2:0])
                     3'd0: hdr_type_in = req_data.data_byte;
                     3'd1: hdr_source_in[15:8] = req_data.data_byte;
                     3'd2: hdr_source_in[7:0] = req_data.data_byte;
                     3'd3: hdr_dest_in[15:8] = req_data.data_byte;
                     3'd4: hdr_dest_in[7:0] = req_data.data_byte;
                     3'd5: hdr_packet_in[15:8] = req_data.data_byte;
                     3'd6: hdr_packet_in[7:0] = req_data.data_byte;
                     default: hdr_length_in = req_data.data_byte;
                  endcase
                  rx_index_in = rx_index_ff + 9'd1;
                  if (rx_index_in >= rffa_pkg::HDR_BYTES) begin
                     for_us = (hdr_dest_in == node_id) ||
                              (hdr_dest_in == rffa_pkg::BROADCAST_ID);
                     rx_mode_in = (for_us && hdr_length_in <= rffa_pkg::MAX_PAYLOAD) ?
                                  MODE_PAYLOAD : MODE_DISCARD;
                  end
               end else begin
                  if (rx_mode_ff == MODE_PAYLOAD && pay_offset < {1'b0, hdr_length_ff}) begin
                     job.rx_put = 1'b1;
                     job.data_byte = req_data.data_byte;
                  end
                  if (rx_index_ff != rffa_pkg::RX_INDEX_MAX) begin
                     rx_index_in = rx_index_ff + 9'd1;
                  end
               end

               if (req_data.rx_last) begin
                  if (rx_index_in < rffa_pkg::HDR_BYTES) begin
                     status = rffa_pkg::STATUS_SHORT;
                  end else if (rx_mode_in == MODE_PAYLOAD) begin
                     status = rffa_pkg::STATUS_DELIVERED;
                  end else if (hdr_dest_in != node_id &&
                               hdr_dest_in != rffa_pkg::BROADCAST_ID) begin
                     status = rffa_pkg::STATUS_NOT_HERE;
                  end else begin
                     status = rffa_pkg::STATUS_TOO_LONG;
                  end
                  job.sum = 1'b1;
                  job.status = status;
                  job.sum_type = hdr_type_in;
                  job.sum_src = hdr_source_in;
                  job.sum_dest = hdr_dest_in;
                  job.sum_pkt = hdr_packet_in;
                  job.sum_len = hdr_length_in;
                  if (status == rffa_pkg::STATUS_DELIVERED &&
                      hdr_dest_in != rffa_pkg::BROADCAST_ID && hdr_type_in != ack_type) begin
                     job.ack = 1'b1;
                     job.tx_type = ack_type;
                     job.tx_dest = hdr_source_in;
                     job.tx_len = rffa_pkg::ACK_PAYLOAD_LEN;
                     job.pid = id_counter_ff;
                     id_counter_in = id_counter_ff + 16'd1;
                  end
                  rx_index_in = '0;
                  rx_mode_in = MODE_HEADER;
               end
               job_valid = job.rx_put || job.sum;
            end
            rffa_pkg::CMD_TX_START: begin
               if (req_data.tx_length > rffa_pkg::MAX_PAYLOAD) begin
                  tx_len = rffa_pkg::MAX_PAYLOAD;
               end
               job.op = rffa_pkg::JOB_TXHDR;
               job.tx_type = req_data.tx_type;
               job.tx_dest = req_data.tx_dest;
               job.tx_len = tx_len;
               job.pid = id_counter_ff;
               id_counter_in = id_counter_ff + 16'd1;
               tx_remaining_in = tx_len;
               job_valid = 1'b1;
            end
            rffa_pkg::CMD_TX_BYTE: begin
               if (tx_remaining_ff != 8'd0) begin
                  tx_remaining_in = tx_remaining_ff - 8'd1;
                  job.op = rffa_pkg::JOB_TXBYTE;
                  job.data_byte = req_data.data_byte;
                  job.fend = (tx_remaining_ff == 8'd1);
                  job_valid = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign push_valid = job_valid;
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_mode_ff <= MODE_HEADER;
         rx_index_ff <= '0;
         hdr_type_ff <= '0;
         hdr_source_ff <= '0;
         hdr_dest_ff <= '0;
         hdr_packet_ff <= '0;
         hdr_length_ff <= '0;
         id_counter_ff <= '0;
         tx_remaining_ff <= '0;
      end else begin
         rx_mode_ff <= rx_mode_in;
         rx_index_ff <= rx_index_in;
         hdr_type_ff <= hdr_type_in;
         hdr_source_ff <= hdr_source_in;
         hdr_dest_ff <= hdr_dest_in;
         hdr_packet_ff <= hdr_packet_in;
         hdr_length_ff <= hdr_length_in;
         id_counter_ff <= id_counter_in;
         tx_remaining_ff <= tx_remaining_in;
      end
   end

endmodule

// ===== hdl/rffa_queue.sv =====
// Job queue between the front end and the back end.
module rffa_queue #(
   parameter int unsigned DEPTH = rffa_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rffa_pkg::job_type push_job,
   input  logic             pop,
   output rffa_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   rffa_pkg::job_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("Job pushed into a full queue.");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("Job popped from an empty queue.");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("Queue count exceeds its depth.");
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !empty)
      else $error("Queue empty after a push without a pop.");
`endif

endmodule

// ===== hdl/rffa_back.sv =====
// Back end: expands each queued job into result beats through an output register.
module rffa_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      node_id,
   input  rffa_pkg::job_type head_job,
   input  logic             q_empty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rffa_pkg::rsp_type rsp_data
);

   localparam logic [3:0] STEP_RX_BYTE  = 4'd0;
   localparam logic [3:0] STEP_SUMMARY  = 4'd1;
   localparam logic [3:0] STEP_HDR_BASE = 4'd2;
   localparam logic [3:0] STEP_HDR_LAST = 4'd9;
   localparam logic [3:0] STEP_ACK_LAST = 4'd11;

   logic [3:0]       step_ff, step_in;
   logic             started_ff, started_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rffa_pkg::rsp_type rsp_data_ff;
   logic [3:0]       first_step;
   logic [3:0]       last_step;
   logic [3:0]       cur_step;
   logic [3:0]       hdr_pos;
   logic             go;
   rffa_pkg::rsp_type beat;

   always_comb begin
      case (head_job.op)
         rffa_pkg::JOB_RX: begin
            first_step = head_job.rx_put ? STEP_RX_BYTE : STEP_SUMMARY;
            last_step = head_job.ack ? STEP_ACK_LAST :
                        (head_job.sum ? STEP_SUMMARY : STEP_RX_BYTE);
         end
         rffa_pkg::JOB_TXHDR: begin
            first_step = STEP_HDR_BASE;
            last_step = STEP_HDR_LAST;
         end
         default: begin
            first_step = STEP_RX_BYTE;
            last_step = STEP_RX_BYTE;
         end
      endcase
   end

   assign cur_step = started_ff ? step_ff : first_step;
   assign hdr_pos = cur_step - STEP_HDR_BASE;
   assign go = !q_empty && (!rsp_valid_ff || rsp_ready);
   assign pop = go && (cur_step == last_step);

   always_comb begin
      beat = '0;
      if (cur_step == STEP_RX_BYTE) begin
         beat.out_byte = head_job.data_byte;
         if (head_job.op == rffa_pkg::JOB_TXBYTE) begin
            beat.kind = rffa_pkg::KIND_TX_BYTE;
            beat.frame_end = head_job.fend;
         end else begin
            beat.kind = rffa_pkg::KIND_RX_BYTE;
         end
      end else if (cur_step == STEP_SUMMARY) begin
         beat.kind = rffa_pkg::KIND_SUMMARY;
         beat.msg_type = head_job.sum_type;
         beat.source_id = head_job.sum_src;
         beat.dest_id = head_job.sum_dest;
         beat.packet_id = head_job.sum_pkt;
         beat.length = head_job.sum_len;
         beat.status = head_job.status;
      end else begin
         beat.kind = rffa_pkg::KIND_TX_BYTE;
         case (hdr_pos)
            4'd0: beat.out_byte = head_job.tx_type;
            4'd1: beat.out_byte = node_id[15:8];
            4'd2: beat.out_byte = node_id[7:0];
            4'd3: beat.out_byte = head_job.tx_dest[15:8];
            4'd4: beat.out_byte = head_job.tx_dest[7:0];
            4'd5: beat.out_byte = head_job.pid[15:8];
            4'd6: beat.out_byte = head_job.pid[7:0];
            4'd7: begin
               beat.out_byte = head_job.tx_len;
               beat.frame_end = (head_job.tx_len == 8'd0);
            end
            4'd8: beat.out_byte = head_job.sum_pkt[15:8];
            4'd9: begin
               beat.out_byte = head_job.sum_pkt[7:0];
               beat.frame_end = 1'b1;
            end
            default: beat.out_byte = '0;
         endcase
      end
   end

   always_comb begin
      step_in = step_ff;
      started_in = started_ff;
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
         if (pop) begin
            started_in = 1'b0;
         end else begin
            started_in = 1'b1;
            step_in = cur_step + 4'd1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         started_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         started_ff <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_data_ff <= beat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ===== hdl/radio_frame_filter_with_auto_ack_unit.sv =====
// Top level of the radio frame filter with auto-ACK: registers, front end, queue, back end.
//
// The input side takes one beat per clock cycle as long as the job queue (QUEUE_DEPTH
// entries) has room; the result side delivers one beat per cycle through an output
// register while rsp_ready is high. A received or transmit payload byte yields one
// result beat, a transmit header eight, and a received frame end one to twelve (payload
// byte, summary and a ten-byte ACK frame). Sustained rate is therefore one item per cycle
// while items yield at most one result each and rsp_ready holds; longer bursts are
// buffered in the queue and throttle the input only once it fills. No clearing after reset.
module radio_frame_filter_with_auto_ack_unit #(
   parameter int unsigned QUEUE_DEPTH = rffa_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rffa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rffa_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   logic [15:0] node_id_ff;
   logic [7:0]  ack_type_ff;
   logic        enabled_ff;

   logic             push_valid;
   rffa_pkg::job_type push_job;
   rffa_pkg::job_type head_job;
   logic             q_full;
   logic             q_empty;
   logic             pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= rffa_pkg::RESET_NODE_ID;
         ack_type_ff <= rffa_pkg::RESET_ACK_TYPE;
         enabled_ff <= rffa_pkg::RESET_ENABLED;
      end else if (csr_write_en) begin
         case (csr_index)
            rffa_pkg::CSR_NODE_ID: node_id_ff <= csr_wdata;
            rffa_pkg::CSR_ACK_TYPE: ack_type_ff <= csr_wdata[7:0];
            rffa_pkg::CSR_ENABLED: enabled_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   rffa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .node_id    (node_id_ff),
      .ack_type   (ack_type_ff),
      .enabled    (enabled_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   rffa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   rffa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .node_id   (node_id_ff),
      .head_job  (head_job),
      .q_empty   (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the radio frame filter with auto-ACK unit.
module tb;

   typedef enum logic [2:0] {
      RX_HEADER  = 3'b001,
      RX_PAYLOAD = 3'b010,
      RX_DISCARD = 3'b100
   } rx_phase_type;

   localparam logic [1:0]  CMD_UNUSED = 2'd3;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned HOLD_CYCLES = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   rffa_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rffa_pkg::rsp_type rsp_data;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = rffa_pkg::CSR_NODE_ID;
   logic [15:0] csr_wdata = '0;

   logic [15:0]  node_addr = rffa_pkg::RESET_NODE_ID;
   logic [7:0]   ack_code = rffa_pkg::RESET_ACK_TYPE;
   logic         unit_on = rffa_pkg::RESET_ENABLED;
   logic [8:0]   rx_count = '0;
   rx_phase_type rx_phase = RX_HEADER;
   logic [7:0]   f_type = '0;
   logic [15:0]  f_source = '0;
   logic [15:0]  f_dest = '0;
   logic [15:0]  f_packet = '0;
   logic [7:0]   f_length = '0;
   logic [15:0]  next_packet_id = '0;
   logic [7:0]   tx_due = '0;

   rffa_pkg::rsp_type due_beats[$];
   int          error_count = 0;
   int unsigned items_sent = 0;
   int          rsp_hold = 0;
   bit          sender_steady = 1'b0;
   bit          receiver_steady = 1'b0;

   radio_frame_filter_with_auto_ack_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void push_beat(logic [1:0] kind, logic [7:0] data, logic fend,
                                     logic [1:0] status);
      rffa_pkg::rsp_type beat;
      beat = '0;
      beat.kind = kind;
      beat.out_byte = data;
      beat.frame_end = fend;
      if (kind == rffa_pkg::KIND_SUMMARY) begin
         beat.msg_type = f_type;
         beat.source_id = f_source;
         beat.dest_id = f_dest;
         beat.packet_id = f_packet;
         beat.length = f_length;
         beat.status = status;
      end
      due_beats.push_back(beat);
   endfunction

   function automatic void push_tx_header(logic [7:0] ttype, logic [15:0] dest,
                                          logic [7:0] len);
      logic [15:0] pid;
      pid = next_packet_id;
      next_packet_id = next_packet_id + 16'd1;
      push_beat(rffa_pkg::KIND_TX_BYTE, ttype, 1'b0, rffa_pkg::STATUS_DELIVERED);
      push_beat(rffa_pkg::KIND_TX_BYTE, node_addr[15:8], 1'b0, rffa_pkg::STATUS_DELIVERED);
      push_beat(rffa_pkg::KIND_TX_BYTE, node_addr[7:0], 1'b0, rffa_pkg::STATUS_DELIVERED);
      push_beat(rffa_pkg::KIND_TX_BYTE, dest[15:8], 1'b0, rffa_pkg::STATUS_DELIVERED);
      push_beat(rffa_pkg::KIND_TX_BYTE, dest[7:0], 1'b0, rffa_pkg::STATUS_DELIVERED);
      push_beat(rffa_pkg::KIND_TX_BYTE, pid[15:8], 1'b0, rffa_pkg::STATUS_DELIVERED);
      push_beat(rffa_pkg::KIND_TX_BYTE, pid[7:0], 1'b0, rffa_pkg::STATUS_DELIVERED);
      push_beat(rffa_pkg::KIND_TX_BYTE, len, len == 8'd0, rffa_pkg::STATUS_DELIVERED);
   endfunction

   function automatic void rx_step(logic [7:0] b, logic last);
      logic [1:0] status;
      if (rx_phase == RX_HEADER) begin
         if (rx_count == 9'd0) begin
            f_type = '0;
            f_source = '0;
            f_dest = '0;
            f_packet = '0;
            f_length = '0;
         end
         case (rx_count)
            9'd0: f_type = b;
            9'd1: f_source[15:8] = b;
            9'd2: f_source[7:0] = b;
            9'd3: f_dest[15:8] = b;
            9'd4: f_dest[7:0] = b;
            9'd5: f_packet[15:8] = b;
            9'd6: f_packet[7:0] = b;
            default: f_length = b;
         endcase
         rx_count = rx_count + 9'd1;
         if (rx_count >= rffa_pkg::HDR_BYTES) begin
            if ((f_dest == node_addr || f_dest == rffa_pkg::BROADCAST_ID) &&
                f_length <= rffa_pkg::MAX_PAYLOAD) begin
               rx_phase = RX_PAYLOAD;
            end else begin
               rx_phase = RX_DISCARD;
            end
         end
      end else begin
         if (rx_phase == RX_PAYLOAD &&
             (rx_count - rffa_pkg::HDR_BYTES) < {1'b0, f_length}) begin
            push_beat(rffa_pkg::KIND_RX_BYTE, b, 1'b0, rffa_pkg::STATUS_DELIVERED);
         end
         if (rx_count < rffa_pkg::RX_INDEX_MAX) begin
            rx_count = rx_count + 9'd1;
         end
      end
      if (last) begin
         if (rx_count < rffa_pkg::HDR_BYTES) begin
            status = rffa_pkg::STATUS_SHORT;
         end else if (rx_phase == RX_PAYLOAD) begin
            status = rffa_pkg::STATUS_DELIVERED;
         end else if (f_dest != node_addr && f_dest != rffa_pkg::BROADCAST_ID) begin
            status = rffa_pkg::STATUS_NOT_HERE;
         end else begin
            status = rffa_pkg::STATUS_TOO_LONG;
         end
         push_beat(rffa_pkg::KIND_SUMMARY, 8'd0, 1'b0, status);
         if (status == rffa_pkg::STATUS_DELIVERED && f_dest != rffa_pkg::BROADCAST_ID &&
             f_type != ack_code) begin
            push_tx_header(ack_code, f_source, rffa_pkg::ACK_PAYLOAD_LEN);
            push_beat(rffa_pkg::KIND_TX_BYTE, f_packet[15:8], 1'b0,
                      rffa_pkg::STATUS_DELIVERED);
            push_beat(rffa_pkg::KIND_TX_BYTE, f_packet[7:0], 1'b1,
                      rffa_pkg::STATUS_DELIVERED);
         end
         rx_count = '0;
         rx_phase = RX_HEADER;
      end
   endfunction

   function automatic void filter_step(rffa_pkg::req_type item);
      logic [7:0] len;
      if (!unit_on) begin
         return;
      end
      case (item.cmd)
         rffa_pkg::CMD_RX_BYTE: rx_step(item.data_byte, item.rx_last);
         rffa_pkg::CMD_TX_START: begin
            len = (item.tx_length > rffa_pkg::MAX_PAYLOAD) ? rffa_pkg::MAX_PAYLOAD :
                  item.tx_length;
            push_tx_header(item.tx_type, item.tx_dest, len);
            tx_due = len;
         end
         rffa_pkg::CMD_TX_BYTE: begin
            if (tx_due != 8'd0) begin
               tx_due = tx_due - 8'd1;
               push_beat(rffa_pkg::KIND_TX_BYTE, item.data_byte, tx_due == 8'd0,
                         rffa_pkg::STATUS_DELIVERED);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      rffa_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_beats.size() == 0) begin
            $error("result beat with nothing expected, kind %0d byte %0d",
                   rsp_data.kind, rsp_data.out_byte);
            error_count++;
         end else begin
            want = due_beats.pop_front();
            check_field("kind", want.kind, rsp_data.kind);
            check_field("out_byte", want.out_byte, rsp_data.out_byte);
            check_field("frame_end", want.frame_end, rsp_data.frame_end);
            check_field("msg_type", want.msg_type, rsp_data.msg_type);
            check_field("source_id", want.source_id, rsp_data.source_id);
            check_field("dest_id", want.dest_id, rsp_data.dest_id);
            check_field("packet_id", want.packet_id, rsp_data.packet_id);
            check_field("length", want.length, rsp_data.length);
            check_field("status", want.status, rsp_data.status);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else if (receiver_steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 19);
      end
   end

   function automatic rffa_pkg::req_type random_req(logic [1:0] cmd);
      rffa_pkg::req_type item;
      item.cmd = cmd;
      item.data_byte = 8'($urandom);
      item.rx_last = 1'($urandom);
      item.tx_type = 8'($urandom);
      item.tx_dest = 16'($urandom);
      item.tx_length = 8'($urandom);
      return item;
   endfunction

   function automatic rffa_pkg::req_type rx_byte_req(logic [7:0] b, logic last);
      rffa_pkg::req_type item;
      item = random_req(rffa_pkg::CMD_RX_BYTE);
      item.data_byte = b;
      item.rx_last = last;
      return item;
   endfunction

   function automatic rffa_pkg::req_type tx_start(logic [7:0] ttype, logic [15:0] dest,
                                                  logic [7:0] len);
      rffa_pkg::req_type item;
      item = random_req(rffa_pkg::CMD_TX_START);
      item.tx_type = ttype;
      item.tx_dest = dest;
      item.tx_length = len;
      return item;
   endfunction

   function automatic rffa_pkg::req_type tx_byte(logic [7:0] b);
      rffa_pkg::req_type item;
      item = random_req(rffa_pkg::CMD_TX_BYTE);
      item.data_byte = b;
      return item;
   endfunction

   task automatic send_item(input rffa_pkg::req_type item);
      if (!sender_steady) begin
         while ($urandom_range(99) < 19) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      filter_step(item);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input logic [15:0] node, input logic [7:0] ack, input logic on);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index <= rffa_pkg::CSR_NODE_ID;
      csr_wdata <= node;
      @(posedge clock);
      csr_index <= rffa_pkg::CSR_ACK_TYPE;
      csr_wdata <= {8'($urandom), ack};
      @(posedge clock);
      csr_index <= rffa_pkg::CSR_ENABLED;
      csr_wdata <= {15'($urandom), on};
      @(posedge clock);
      csr_write_en <= 1'b0;
      node_addr = node;
      ack_code = ack;
      unit_on = on;
   endtask

   task automatic send_rx_frame(input logic [7:0] ftype, input logic [15:0] src,
                                input logic [15:0] dest, input logic [15:0] pkt,
                                input logic [7:0] len, input int unsigned total,
                                input bit mix_tx);
      logic [63:0] hdr;
      logic [7:0]  b;
      hdr = {ftype, src, dest, pkt, len};
      for (int unsigned i = 0; i < total; i++) begin
         b = (i < 8) ? hdr[8 * (7 - i) +: 8] : 8'($urandom);
         if (mix_tx && $urandom_range(9) == 0) begin
            send_item(tx_byte(8'($urandom)));
         end
         send_item(rx_byte_req(b, i == total - 1));
      end
   endtask

   task automatic random_rx_frame();
      int unsigned pick;
      int unsigned total;
      logic [15:0] dest;
      logic [7:0]  ftype;
      logic [7:0]  len;
      pick = $urandom_range(99);
      if (pick < 45) begin
         dest = node_addr;
      end else if (pick < 65) begin
         dest = rffa_pkg::BROADCAST_ID;
      end else begin
         dest = 16'($urandom);
      end
      ftype = ($urandom_range(3) == 0) ? ack_code : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 75) begin
         len = 8'($urandom_range(4));
      end else if (pick < 85) begin
         len = rffa_pkg::MAX_PAYLOAD;
      end else begin
         len = 8'($urandom_range(255, 241));
      end
      if ($urandom_range(9) == 0) begin
         total = $urandom_range(7, 1);
      end else if (len > 8'd4) begin
         total = 8 + $urandom_range(6);
      end else begin
         total = 8 + $urandom_range(len + 2);
      end
      send_rx_frame(ftype, 16'($urandom), dest, 16'($urandom), len, total,
                    $urandom_range(4) == 0);
   endtask

   task automatic random_tx_frame();
      logic [7:0]  len;
      logic [15:0] dest;
      int unsigned count;
      len = ($urandom_range(6) == 0) ? 8'($urandom) : 8'($urandom_range(4));
      dest = ($urandom_range(9) == 0) ? rffa_pkg::BROADCAST_ID : 16'($urandom);
      send_item(tx_start(8'($urandom), dest, len));
      count = (len > 8'd5) ? $urandom_range(6) : $urandom_range(len + 1);
      repeat (count) send_item(tx_byte(8'($urandom)));
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned first;
      int unsigned pick;
      first = items_sent;
      while (items_sent - first < count) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            random_rx_frame();
         end else if (pick < 85) begin
            random_tx_frame();
         end else begin
            send_item(random_req(2'($urandom)));
         end
      end
   endtask

   task automatic test_transmit();
      send_item(tx_start(8'hFF, rffa_pkg::BROADCAST_ID, 8'd0));
      send_item(tx_start(8'h00, 16'h0000, 8'd255));
      send_item(tx_byte(8'h00));
      send_item(tx_byte(8'hFF));
      send_item(tx_start(8'hA5, 16'h5A5A, 8'd1));
      send_item(tx_byte(8'h3C));
      send_item(tx_byte(8'hC3));
      send_item(random_req(CMD_UNUSED));
   endtask

   task automatic test_rx_filters();
      send_rx_frame(8'h07, 16'h80FF, node_addr, 16'h0000, 8'd0, 2, 1'b0);
      send_rx_frame(8'h00, 16'h1234, node_addr ^ 16'h0001, 16'h5678, 8'hFF, 9, 1'b0);
      send_rx_frame(8'h00, rffa_pkg::BROADCAST_ID, node_addr, 16'hFFFF, 8'd0, 9, 1'b0);
   endtask

   task automatic test_disabled();
      logic [63:0] hdr;
      hdr = {8'h11, 16'h2233, node_addr, 16'hBEEF, 8'd1};
      for (int i = 0; i < 3; i++) begin
         send_item(rx_byte_req(hdr[8 * (7 - i) +: 8], 1'b0));
      end
      apply_config(node_addr, ack_code, 1'b0);
      send_item(tx_start(8'h42, 16'h0042, 8'd3));
      send_item(rx_byte_req(8'hFF, 1'b1));
      send_item(tx_byte(8'h55));
      apply_config(node_addr, ack_code, 1'b1);
      for (int i = 3; i < 8; i++) begin
         send_item(rx_byte_req(hdr[8 * (7 - i) +: 8], 1'b0));
      end
      send_item(rx_byte_req(8'h99, 1'b1));
   endtask

   task automatic test_long_frame();
      send_rx_frame(8'h21, 16'h0102, node_addr, 16'h0304, 8'd2, 24, 1'b0);
   endtask

   task automatic test_backpressure();
      rsp_hold = HOLD_CYCLES;
      sender_steady = 1'b1;
      repeat (12) send_item(tx_start(8'($urandom), 16'($urandom), 8'd0));
      sender_steady = 1'b0;
   endtask

   task automatic test_random_traffic();
      apply_config(16'($urandom), 8'($urandom), 1'b1);
      random_phase(40);
      apply_config(rffa_pkg::BROADCAST_ID, 8'hFF, 1'b1);
      random_phase(35);
      apply_config(16'h0000, 8'h00, 1'b1);
      sender_steady = 1'b1;
      receiver_steady = 1'b1;
      random_phase(40);
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      apply_config(16'($urandom), 8'($urandom), 1'b1);
      random_phase(40);
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_transmit();
      test_rx_filters();
      test_disabled();
      test_long_frame();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      if (error_count == 0) begin
         $display("PASS radio_frame_filter_with_auto_ack_unit");
      end else begin
         $display("FAIL radio_frame_filter_with_auto_ack_unit");
      end
      $finish;
   end

   initial begin : watchdog
      #200000;
      $display("FAIL radio_frame_filter_with_auto_ack_unit");
      $finish;
   end

endmodule
